// File: hw/rtl/adac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adac_pkg;

  localparam int FIFO_DEPTH_DEF = 4096;

  // item kinds
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PULL  = 2'd2;
  localparam logic [1:0] MODE_DRAIN = 2'd3;

  // register map
  localparam logic [11:0] OFF_CTRL       = 12'h000;
  localparam logic [11:0] OFF_STATUS     = 12'h004;
  localparam logic [11:0] OFF_SAMPLERATE = 12'h008;
  localparam logic [11:0] OFF_DATA       = 12'h00C;
  localparam logic [11:0] OFF_INTCTRL    = 12'h010;
  localparam logic [11:0] OFF_INTSTAT    = 12'h014;
  localparam logic [11:0] OFF_BUFAVAIL   = 12'h018;
  localparam logic [11:0] OFF_VOLUME     = 12'h01C;

  localparam logic [31:0] DEFAULT_RATE = 32'd16000;
  localparam logic [6:0]  VOLUME_MAX   = 7'd100;
  localparam logic [7:0]  GAIN_MAX     = 8'd255;
  localparam logic [31:0] STATUS_READY = 32'd1;

  // x / 100 == (x * 5243) >> 19 for x up to 100 * 255
  localparam logic [12:0] GAIN_RECIP = 13'd5243;
  localparam int          GAIN_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    logic [15:0] push_data;
  } fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/adac_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module adac_fifo #(
  parameter int FIFO_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire adac_pkg::fifo_cmd_t               cmd,
  output adac_pkg::fifo_stat_t                   stat,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]        level,
  output logic [15:0]                            rd_data
);
  import adac_pkg::*;

  localparam int IW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);

  logic [15:0]   mem [FIFO_DEPTH];
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] fill;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= cmd.push_data;
    end
    if (cmd.pop) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      fill   <= '0;
    end else if (cmd.clear) begin
      wr_idx <= '0;
      rd_idx <= '0;
      fill   <= '0;
    end else begin
      if (cmd.push) begin
        wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
      end
      if (cmd.pop) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
      // push and pop never come from the same item
      if (cmd.push && !cmd.pop) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign stat.full  = (fill == DEPTH_CNT);
  assign stat.empty = (fill == '0);
  assign level      = fill;

endmodule

`default_nettype wire

// File: hw/rtl/adac_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module adac_regs #(
  parameter int FIFO_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  input  wire adac_pkg::item_t                   item,
  input  wire adac_pkg::fifo_stat_t              fstat,
  input  wire logic [$clog2(FIFO_DEPTH+1)-1:0]   flevel,
  output adac_pkg::fifo_cmd_t                    fcmd,
  output logic [31:0]                            read_data,
  output logic                                   bad_offset,
  output logic                                   popped,
  output logic                                   irq_level,
  output logic [7:0]                             gain,
  output logic [31:0]                            sink_rate,
  output logic                                   active
);
  import adac_pkg::*;

  localparam logic [31:0] DEPTH32 = 32'(FIFO_DEPTH);

  logic        enable;
  logic        enable_next;
  logic [31:0] rate;
  logic [31:0] rate_next;
  logic        irq_en;
  logic        irq_en_next;
  logic        irq_pend;
  logic        irq_pend_next;
  logic [6:0]  volume;
  logic [6:0]  volume_next;
  logic [31:0] latched;
  logic [31:0] latched_next;
  logic [7:0]  gain_reg;
  logic [7:0]  gain_next;

  logic [31:0] rdata_next;
  logic        bad_next;
  logic        pop_next;
  logic [14:0] vol_x255;
  logic [27:0] gain_prod;

  always_comb begin
    enable_next   = enable;
    rate_next     = rate;
    irq_en_next   = irq_en;
    irq_pend_next = irq_pend;
    volume_next   = volume;
    latched_next  = latched;
    rdata_next    = '0;
    bad_next      = 1'b0;
    pop_next      = 1'b0;
    fcmd          = '0;
    fcmd.push_data = item.write_data[15:0];

    if (item_valid) begin
      unique case (item.mode)
        MODE_READ: begin
          unique case (item.reg_offset)
            OFF_CTRL:       rdata_next = {31'd0, enable};
            OFF_STATUS:     rdata_next = STATUS_READY;
            OFF_SAMPLERATE: rdata_next = rate;
            OFF_INTCTRL:    rdata_next = {31'd0, irq_en};
            OFF_INTSTAT:    rdata_next = {31'd0, irq_pend};
            OFF_BUFAVAIL:   rdata_next = DEPTH32 - 32'(flevel);
            OFF_VOLUME:     rdata_next = {25'd0, volume};
            default:        bad_next = 1'b1;
          endcase
        end
        MODE_WRITE: begin
          unique case (item.reg_offset)
            OFF_CTRL: begin
              if (item.write_data[0] && !enable) begin
                fcmd.clear    = 1'b1;
                latched_next  = (rate == '0) ? DEFAULT_RATE : rate;
                irq_pend_next = 1'b1;
              end else if (!item.write_data[0] && enable) begin
                fcmd.clear = 1'b1;
              end
              enable_next = item.write_data[0];
            end
            OFF_SAMPLERATE: rate_next = item.write_data;
            OFF_DATA:       fcmd.push = enable && !fstat.full;
            OFF_INTCTRL:    irq_en_next = item.write_data[0];
            OFF_INTSTAT:    irq_pend_next = irq_pend & ~item.write_data[0];
            OFF_VOLUME: begin
              volume_next = (item.write_data > 32'(VOLUME_MAX)) ? VOLUME_MAX
                                                                 : item.write_data[6:0];
            end
            default:        bad_next = 1'b1;
          endcase
        end
        MODE_PULL: begin
          pop_next = enable && !fstat.empty;
          fcmd.pop = pop_next;
        end
        MODE_DRAIN: begin
          if (enable) begin
            irq_pend_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // volume * 255 / 100 by reciprocal multiply
  assign vol_x255  = {volume_next, 8'd0} - 15'(volume_next);
  assign gain_prod = 28'(vol_x255) * 28'(GAIN_RECIP);
  assign gain_next = gain_prod[GAIN_SHIFT +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      rate       <= DEFAULT_RATE;
      irq_en     <= 1'b0;
      irq_pend   <= 1'b0;
      volume     <= VOLUME_MAX;
      latched    <= DEFAULT_RATE;
      gain_reg   <= GAIN_MAX;
      popped     <= 1'b0;
      bad_offset <= 1'b0;
    end else begin
      enable     <= enable_next;
      rate       <= rate_next;
      irq_en     <= irq_en_next;
      irq_pend   <= irq_pend_next;
      volume     <= volume_next;
      latched    <= latched_next;
      gain_reg   <= gain_next;
      popped     <= pop_next;
      bad_offset <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    read_data <= rdata_next;
  end

  // state registers already hold the after-item values during the result cycle
  assign irq_level = irq_pend & irq_en;
  assign gain      = gain_reg;
  assign sink_rate = latched;
  assign active    = enable;

endmodule

`default_nettype wire

// File: hw/rtl/audio_dac_sample_fifo_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted item is registered into in_item and in_valid, then processed into
// the state registers and read_data; its result shows as done, registered from in_valid, goes high
// throughput: one item per cycle, busy stays low; the receiver cannot stall
// reset: synchronous active-high rst clears control, registers and fifo pointers;
// the sample memory is not cleared, only pushed entries are ever popped

module audio_dac_sample_fifo_regs #(
  parameter int FIFO_DEPTH = adac_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [11:0]        reg_offset,
  input  wire logic [31:0]        write_data,
  output logic                    done,
  output logic [31:0]             read_data,
  output logic                    bad_offset,
  output logic signed [15:0]      sample_out,
  output logic                    sample_valid,
  output logic                    irq_level,
  output logic [7:0]              gain,
  output logic [31:0]             sink_rate,
  output logic                    active
);
  import adac_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic          in_valid;
  item_t         in_item;
  fifo_cmd_t     fcmd;
  fifo_stat_t    fstat;
  logic [CW-1:0] flevel;
  logic [15:0]   fifo_q;
  logic          popped;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    in_item.mode       <= mode;
    in_item.reg_offset <= reg_offset;
    in_item.write_data <= write_data;
  end

  adac_regs #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_item),
    .fstat      (fstat),
    .flevel     (flevel),
    .fcmd       (fcmd),
    .read_data  (read_data),
    .bad_offset (bad_offset),
    .popped     (popped),
    .irq_level  (irq_level),
    .gain       (gain),
    .sink_rate  (sink_rate),
    .active     (active)
  );

  adac_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fcmd),
    .stat    (fstat),
    .level   (flevel),
    .rd_data (fifo_q)
  );

  assign sample_valid = done && popped;
  assign sample_out   = sample_valid ? $signed(fifo_q) : 16'sd0;

  a_pop_needs_run: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> active)
    else $error("sample popped while stopped");

  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("registered item did not produce a result");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    flevel <= CW'(FIFO_DEPTH))
    else $error("fifo level above depth");

  a_pop_not_bad: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> !bad_offset)
    else $error("pull flagged as bad offset");

endmodule

`default_nettype wire

// File: verif/tb_audio_dac_sample_fifo_regs.sv
`timescale 1ns / 1ps

module tb_audio_dac_sample_fifo_regs;
  import adac_pkg::*;

  localparam int DEPTH        = FIFO_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    item_t       op;
    int unsigned idle;
  } queued_op_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        bad;
    logic [15:0] pcm;
    logic        pcm_ok;
    logic        irq;
    logic [7:0]  gain;
    logic [31:0] rate;
    logic        run;
  } dac_out_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic [1:0]         mode       = MODE_READ;
  logic [11:0]        reg_offset = OFF_CTRL;
  logic [31:0]        write_data = '0;
  logic               busy;
  logic               done;
  logic [31:0]        read_data;
  logic               bad_offset;
  logic signed [15:0] sample_out;
  logic               sample_valid;
  logic               irq_level;
  logic [7:0]         gain;
  logic [31:0]        sink_rate;
  logic               active;

  // testbench copy of the peripheral state
  logic        run_q;
  logic [31:0] rate_q;
  logic        irq_en_q;
  logic        pend_q;
  logic [6:0]  vol_q;
  logic [31:0] lat_rate_q;
  logic [15:0] pcm_mem [DEPTH];
  int          wr_ptr;
  int          rd_ptr;
  int          fill_lvl;

  queued_op_t  pending_ops[$];
  dac_out_t    due_outputs[$];
  queued_op_t  next_op;
  logic        item_taken   = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned calm_left    = 0;
  int          op_count     = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;

  audio_dac_sample_fifo_regs u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .reg_offset   (reg_offset),
    .write_data   (write_data),
    .done         (done),
    .read_data    (read_data),
    .bad_offset   (bad_offset),
    .sample_out   (sample_out),
    .sample_valid (sample_valid),
    .irq_level    (irq_level),
    .gain         (gain),
    .sink_rate    (sink_rate),
    .active       (active)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int bump(int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  task automatic flush_fifo();
    wr_ptr   = 0;
    rd_ptr   = 0;
    fill_lvl = 0;
  endtask

  task automatic dac_reset_state();
    run_q      = 1'b0;
    rate_q     = DEFAULT_RATE;
    irq_en_q   = 1'b0;
    pend_q     = 1'b0;
    vol_q      = VOLUME_MAX;
    lat_rate_q = DEFAULT_RATE;
    flush_fifo();
  endtask

  // advance the state by one item and queue the output it should produce
  task automatic play_dac_item(input item_t it);
    dac_out_t r;
    r = '0;
    case (it.mode)
      MODE_READ: begin
        case (it.reg_offset)
          OFF_CTRL:       r.rdata = {31'd0, run_q};
          OFF_STATUS:     r.rdata = STATUS_READY;
          OFF_SAMPLERATE: r.rdata = rate_q;
          OFF_INTCTRL:    r.rdata = {31'd0, irq_en_q};
          OFF_INTSTAT:    r.rdata = {31'd0, pend_q};
          OFF_BUFAVAIL:   r.rdata = 32'(DEPTH - fill_lvl);
          OFF_VOLUME:     r.rdata = {25'd0, vol_q};
          default:        r.bad = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        case (it.reg_offset)
          OFF_CTRL: begin
            if (it.write_data[0] && !run_q) begin
              flush_fifo();
              lat_rate_q = (rate_q == '0) ? DEFAULT_RATE : rate_q;
              pend_q = 1'b1;
            end else if (!it.write_data[0] && run_q) begin
              flush_fifo();
            end
            run_q = it.write_data[0];
          end
          OFF_SAMPLERATE: rate_q = it.write_data;
          OFF_DATA: begin
            if (run_q && fill_lvl < DEPTH) begin
              pcm_mem[wr_ptr] = it.write_data[15:0];
              wr_ptr = bump(wr_ptr);
              fill_lvl++;
            end
          end
          OFF_INTCTRL: irq_en_q = it.write_data[0];
          OFF_INTSTAT: begin
            if (it.write_data[0]) pend_q = 1'b0;
          end
          OFF_VOLUME: vol_q = (it.write_data > VOLUME_MAX) ? VOLUME_MAX : it.write_data[6:0];
          default:    r.bad = 1'b1;
        endcase
      end
      MODE_PULL: begin
        if (run_q && fill_lvl > 0) begin
          r.pcm    = pcm_mem[rd_ptr];
          r.pcm_ok = 1'b1;
          rd_ptr   = bump(rd_ptr);
          fill_lvl--;
        end
      end
      default: begin
        if (run_q) pend_q = 1'b1;
      end
    endcase
    r.irq  = pend_q & irq_en_q;
    r.gain = 8'((int'(vol_q) * int'(GAIN_MAX)) / int'(VOLUME_MAX));
    r.rate = lat_rate_q;
    r.run  = run_q;
    due_outputs.push_back(r);
  endtask

  // mostly short gaps, a few long ones, and now and then a run with none
  function int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 3) begin
      calm_left = $urandom_range(60, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic add_op(input logic [1:0] m, input logic [11:0] off, input logic [31:0] d);
    queued_op_t q;
    q.op.mode       = m;
    q.op.reg_offset = off;
    q.op.write_data = d;
    q.idle          = pick_idle();
    pending_ops.push_back(q);
    op_count++;
  endtask

  function automatic logic [11:0] pick_reg();
    case ($urandom_range(7))
      0:       return OFF_CTRL;
      1:       return OFF_STATUS;
      2:       return OFF_SAMPLERATE;
      3:       return OFF_DATA;
      4:       return OFF_INTCTRL;
      5:       return OFF_INTSTAT;
      6:       return OFF_BUFAVAIL;
      default: return OFF_VOLUME;
    endcase
  endfunction

  task automatic add_running_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30)      add_op(MODE_WRITE, OFF_DATA, $urandom());
    else if (r < 55) add_op(MODE_PULL, pick_reg(), $urandom());
    else if (r < 70) add_op(MODE_READ, pick_reg(), $urandom());
    else if (r < 75) add_op(MODE_WRITE, OFF_INTSTAT, $urandom());
    else if (r < 78) add_op(MODE_DRAIN, pick_reg(), $urandom());
    else if (r < 82) add_op(MODE_WRITE, OFF_VOLUME,
                            $urandom_range(1) ? $urandom() : $urandom_range(127));
    else if (r < 85) add_op(MODE_WRITE, OFF_INTCTRL, $urandom());
    else if (r < 87) add_op(MODE_WRITE, OFF_SAMPLERATE, $urandom());
    else if (r < 89) add_op(MODE_WRITE, OFF_CTRL, $urandom());
    else             add_op(2'($urandom_range(3)), 12'($urandom_range(4095)), $urandom());
  endtask

  task automatic add_session();
    if ($urandom_range(9) < 7)
      add_op(MODE_WRITE, OFF_SAMPLERATE, ($urandom_range(3) == 0) ? 32'd0 : $urandom());
    if ($urandom_range(1))
      add_op(MODE_WRITE, OFF_VOLUME, $urandom_range(1) ? $urandom() : $urandom_range(127));
    if ($urandom_range(1))
      add_op(MODE_WRITE, OFF_INTCTRL, $urandom());
    add_op(MODE_WRITE, OFF_CTRL, $urandom() | 32'd1);
    repeat ($urandom_range(80, 8)) add_running_op();
    if ($urandom_range(9) < 7)
      add_op(MODE_WRITE, OFF_CTRL, $urandom() & 32'hFFFF_FFFE);
  endtask

  task automatic report_miss(input string what, input dac_out_t want, input dac_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: exp rd=%h bad=%b smp=%h sv=%b irq=%b gain=%0d rate=%0d act=%b",
               $time, what, want.rdata, want.bad, want.pcm, want.pcm_ok, want.irq,
               want.gain, want.rate, want.run,
               "\n    got rd=%h bad=%b smp=%h sv=%b irq=%b gain=%0d rate=%0d act=%b",
               got.rdata, got.bad, got.pcm, got.pcm_ok, got.irq, got.gain, got.rate, got.run);
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || item_taken)) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        start <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        hold_left = next_op.idle;
        start      <= 1'b1;
        mode       <= next_op.op.mode;
        reg_offset <= next_op.op.reg_offset;
        write_data <= next_op.op.write_data;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predict on acceptance, then check any output shown in the closing cycle
  always @(posedge clk) begin
    dac_out_t got;
    dac_out_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      if (start && !busy) begin
        play_dac_item({mode, reg_offset, write_data});
        item_taken <= 1'b1;
      end else begin
        item_taken <= 1'b0;
      end
      if (done) begin
        got = {read_data, bad_offset, sample_out, sample_valid, irq_level, gain,
               sink_rate, active};
        if (due_outputs.size() == 0) begin
          report_miss("unexpected output", '0, got);
        end else begin
          want = due_outputs.pop_front();
          if (got !== want) report_miss("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_audio_dac_sample_fifo_regs failed");
      $finish;
    end
  end

  initial begin
    int base;
    dac_reset_state();

    // stopped: register defaults, unmapped offsets, ignored pushes and pulls
    add_op(MODE_READ, OFF_CTRL, '0);
    add_op(MODE_READ, OFF_STATUS, '0);
    add_op(MODE_READ, OFF_SAMPLERATE, '0);
    add_op(MODE_READ, OFF_BUFAVAIL, '0);
    add_op(MODE_READ, OFF_VOLUME, '0);
    add_op(MODE_READ, OFF_DATA, '0);
    add_op(MODE_READ, 12'h002, '0);
    add_op(MODE_READ, 12'hFFC, '0);
    add_op(MODE_PULL, OFF_CTRL, '0);
    add_op(MODE_DRAIN, OFF_CTRL, '0);
    add_op(MODE_WRITE, OFF_DATA, 32'h0000_1234);
    // start with a zero rate falls back to the default sink rate
    add_op(MODE_WRITE, OFF_SAMPLERATE, 32'd0);
    add_op(MODE_WRITE, OFF_INTCTRL, 32'd1);
    add_op(MODE_WRITE, OFF_CTRL, 32'd1);
    add_op(MODE_WRITE, OFF_CTRL, 32'd3);
    add_op(MODE_WRITE, OFF_INTSTAT, 32'hFFFF_FFFE);
    add_op(MODE_WRITE, OFF_INTSTAT, 32'd1);
    add_op(MODE_WRITE, OFF_DATA, 32'hFFFF_8000);
    add_op(MODE_WRITE, OFF_DATA, 32'h0000_7FFF);
    add_op(MODE_PULL, OFF_CTRL, '0);
    add_op(MODE_PULL, OFF_CTRL, '0);
    add_op(MODE_PULL, OFF_CTRL, '0);
    add_op(MODE_DRAIN, OFF_CTRL, '0);
    add_op(MODE_WRITE, OFF_VOLUME, 32'hFFFF_FFFF);
    add_op(MODE_WRITE, OFF_VOLUME, 32'd0);
    add_op(MODE_WRITE, OFF_STATUS, 32'd1);
    add_op(MODE_WRITE, OFF_BUFAVAIL, 32'd1);
    add_op(MODE_WRITE, 12'hFFF, 32'd1);
    add_op(MODE_WRITE, OFF_CTRL, 32'd0);

    // push a burst, then pull past empty
    add_op(MODE_WRITE, OFF_SAMPLERATE, 32'hFFFF_FFFF);
    add_op(MODE_WRITE, OFF_CTRL, 32'd1);
    repeat (100) add_op(MODE_WRITE, OFF_DATA, $urandom());
    add_op(MODE_READ, OFF_BUFAVAIL, '0);
    repeat (104) add_op(MODE_PULL, OFF_CTRL, '0);
    add_op(MODE_READ, OFF_BUFAVAIL, '0);
    add_op(MODE_WRITE, OFF_CTRL, 32'd0);

    base = op_count;
    while (op_count - base < RANDOM_ITEMS) add_session();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || start) @(posedge clk);
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_audio_dac_sample_fifo_regs passed");
    end else begin
      $display("tb_audio_dac_sample_fifo_regs failed");
    end
    $finish;
  end

endmodule
